FILE: hw/rtl/rast_pkg.sv
`default_nettype none
package rast_pkg;

    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int SPAN_W      = IDX_W + 1;
    localparam int TREE_DEPTH  = 4096;
    localparam int NODE_W      = $clog2(TREE_DEPTH);
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH) + 1;

    localparam logic [IDX_W-1:0] LAST_INDEX_RESET = 10'd1023;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUM = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic              right;
        logic [VAL_W-1:0]  left_sum;
    } frame_t;

endpackage
`default_nettype wire

FILE: hw/rtl/range_add_range_sum_tree_top.sv
`default_nettype none
// Lazy segment tree over up to 1024 signed 32-bit elements: opcode 0 adds
// s_add_value over [range_low, range_high] and returns zero, opcode 1 returns
// the wrapped sum over that range. The walk is run by a sequencer with an
// explicit return stack over two node memories with one read and one write
// port each (sums and pending adds, 4096 words each). Each visited node
// passes through read, settle and two child pending-update states; a node
// that splits the range is returned to after each child, and on an add its
// sum is then recombined from both children. An empty range (low above
// high) goes straight to the result without walking the tree. The block is
// not ready while a word is in progress, and a finished result waits until
// the previous one is taken. After reset a clearing pass over all 4096 words
// zeroes both memories before the first word is accepted; last_index may be
// written at any time the block is idle.
module range_add_range_sum_tree_top (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_we,
    input  wire        [rast_pkg::IDX_W-1:0]      cfg_wdata,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_opcode,
    input  wire        [rast_pkg::IDX_W-1:0]      s_range_low,
    input  wire        [rast_pkg::IDX_W-1:0]      s_range_high,
    input  wire signed [rast_pkg::VAL_W-1:0]      s_add_value,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic signed [rast_pkg::VAL_W-1:0]     m_range_sum
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_SETTLE, ST_PUSH1, ST_PUSH2,
        ST_RET, ST_CMB0, ST_CMB1, ST_CMB2, ST_FIN
    } state_t;

    state_t state_reg;

    logic [rast_pkg::VAL_W-1:0]  sum_mem  [rast_pkg::TREE_DEPTH];
    logic [rast_pkg::VAL_W-1:0]  pend_mem [rast_pkg::TREE_DEPTH];
    logic [rast_pkg::VAL_W-1:0]  sum_q, pend_q;
    logic [rast_pkg::NODE_W-1:0] sum_raddr, pend_raddr, sum_waddr, pend_waddr;
    logic [rast_pkg::VAL_W-1:0]  sum_wdata, pend_wdata;
    logic                        sum_we, pend_we;

    rast_pkg::frame_t            stack_reg [rast_pkg::STACK_DEPTH];
    logic [rast_pkg::SP_W-1:0]   sp_reg;
    logic [rast_pkg::NODE_W-1:0] clr_reg;
    logic [rast_pkg::IDX_W-1:0]  last_index_reg;

    logic                        op_reg;
    logic [rast_pkg::IDX_W-1:0]  ql_reg, qh_reg, lo_reg, hi_reg;
    logic [rast_pkg::VAL_W-1:0]  amount_reg, delta_reg, s_reg, prod_reg, ret_reg;
    logic                        disj_reg, full_reg;
    logic                        m_valid_reg;
    logic [rast_pkg::VAL_W-1:0]  m_sum_reg;

    logic [rast_pkg::NODE_W-1:0] node_reg, child_l, child_r;
    logic [rast_pkg::SPAN_W-1:0] span, mid_sum, top_mid_sum;
    logic [rast_pkg::IDX_W-1:0]  mid, top_mid;
    logic                        leaf, disj_now, full_now;
    logic [rast_pkg::VAL_W-1:0]  nsum;
    logic [rast_pkg::SP_W-1:0]   top;
    rast_pkg::frame_t            top_f;

    assign child_l  = {node_reg[rast_pkg::NODE_W-2:0], 1'b0};
    assign child_r  = {node_reg[rast_pkg::NODE_W-2:0], 1'b1};
    assign span     = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[rast_pkg::SPAN_W-1:1];
    assign leaf     = (lo_reg == hi_reg);
    assign disj_now = (hi_reg < ql_reg) || (qh_reg < lo_reg);
    assign full_now = (ql_reg <= lo_reg) && (hi_reg <= qh_reg);
    assign nsum     = s_reg + prod_reg;
    assign top      = sp_reg - 1'b1;
    assign top_f    = stack_reg[top[rast_pkg::SP_W-2:0]];
    assign top_mid_sum = {1'b0, top_f.lo} + {1'b0, top_f.hi};
    assign top_mid  = top_mid_sum[rast_pkg::SPAN_W-1:1];

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_sum_reg;

    always_comb begin
        sum_raddr  = node_reg;
        pend_raddr = node_reg;
        sum_we     = 1'b0;
        pend_we    = 1'b0;
        sum_waddr  = node_reg;
        pend_waddr = node_reg;
        sum_wdata  = nsum;
        pend_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                sum_we     = 1'b1;
                pend_we    = 1'b1;
                sum_waddr  = clr_reg;
                pend_waddr = clr_reg;
                sum_wdata  = '0;
            end
            ST_SETTLE: begin
                pend_we    = 1'b1;
                pend_raddr = child_l;
            end
            ST_PUSH1: begin
                pend_we    = !leaf;
                pend_waddr = child_l;
                pend_wdata = pend_q + delta_reg;
                pend_raddr = child_r;
            end
            ST_PUSH2: begin
                pend_we    = !leaf;
                pend_waddr = child_r;
                pend_wdata = pend_q + delta_reg;
                sum_we     = 1'b1;
            end
            ST_CMB0: sum_raddr = child_l;
            ST_CMB1: sum_raddr = child_r;
            ST_CMB2: begin
                sum_we    = 1'b1;
                sum_wdata = s_reg + sum_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (pend_we) begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        sum_q  <= sum_mem[sum_raddr];
        pend_q <= pend_mem[pend_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            sp_reg         <= '0;
            last_index_reg <= rast_pkg::LAST_INDEX_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                last_index_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_opcode;
                        ql_reg     <= s_range_low;
                        qh_reg     <= s_range_high;
                        amount_reg <= s_add_value;
                        lo_reg     <= '0;
                        hi_reg     <= last_index_reg;
                        node_reg   <= rast_pkg::NODE_W'(1);
                        sp_reg     <= '0;
                        ret_reg    <= '0;
                        state_reg  <= (s_range_low <= s_range_high) ? ST_RD : ST_FIN;
                    end
                end
                ST_RD: state_reg <= ST_SETTLE;
                ST_SETTLE: begin
                    s_reg    <= sum_q;
                    disj_reg <= disj_now;
                    full_reg <= full_now;
                    delta_reg <= pend_q +
                        ((!disj_now && full_now && op_reg == rast_pkg::OP_ADD) ?
                         amount_reg : '0);
                    state_reg <= ST_PUSH1;
                end
                ST_PUSH1: begin
                    prod_reg  <= rast_pkg::VAL_W'({{(rast_pkg::VAL_W-rast_pkg::SPAN_W){1'b0}},
                                                  span} * delta_reg);
                    state_reg <= ST_PUSH2;
                end
                ST_PUSH2: begin
                    if (disj_reg) begin
                        ret_reg   <= '0;
                        state_reg <= ST_RET;
                    end else if (full_reg) begin
                        ret_reg   <= nsum;
                        state_reg <= ST_RET;
                    end else begin
                        stack_reg[sp_reg[rast_pkg::SP_W-2:0]] <= '{node: node_reg,
                            lo: lo_reg, hi: hi_reg, right: 1'b0, left_sum: '0};
                        sp_reg    <= sp_reg + 1'b1;
                        node_reg  <= child_l;
                        hi_reg    <= mid;
                        state_reg <= ST_RD;
                    end
                end
                ST_RET: begin
                    if (sp_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else if (!top_f.right) begin
                        stack_reg[top[rast_pkg::SP_W-2:0]].right    <= 1'b1;
                        stack_reg[top[rast_pkg::SP_W-2:0]].left_sum <= ret_reg;
                        node_reg  <= {top_f.node[rast_pkg::NODE_W-2:0], 1'b1};
                        lo_reg    <= top_mid + 1'b1;
                        hi_reg    <= top_f.hi;
                        state_reg <= ST_RD;
                    end else if (op_reg == rast_pkg::OP_SUM) begin
                        ret_reg <= top_f.left_sum + ret_reg;
                        sp_reg  <= top;
                    end else begin
                        node_reg  <= top_f.node;
                        state_reg <= ST_CMB0;
                    end
                end
                ST_CMB0: state_reg <= ST_CMB1;
                ST_CMB1: begin
                    s_reg     <= sum_q;
                    state_reg <= ST_CMB2;
                end
                ST_CMB2: begin
                    sp_reg    <= top;
                    state_reg <= ST_RET;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_sum_reg   <= (op_reg == rast_pkg::OP_SUM) ? ret_reg : '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
module tb;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [rast_pkg::IDX_W-1:0]        cfg_wdata = '0;
    logic                              s_valid = 1'b0;
    wire                               s_ready;
    logic                              s_opcode = rast_pkg::OP_ADD;
    logic [rast_pkg::IDX_W-1:0]        s_range_low = '0;
    logic [rast_pkg::IDX_W-1:0]        s_range_high = '0;
    logic signed [rast_pkg::VAL_W-1:0] s_add_value = '0;
    wire                               m_valid;
    logic                              m_ready = 1'b0;
    wire signed [rast_pkg::VAL_W-1:0]  m_range_sum;

    range_add_range_sum_tree_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_range_low(s_range_low), .s_range_high(s_range_high),
        .s_add_value(s_add_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_range_sum(m_range_sum)
    );

    always #5 aclk = ~aclk;

    localparam int CYCLE_LIMIT = 2000000;

    // shadow of the tree
    logic [rast_pkg::VAL_W-1:0] tree_sum [rast_pkg::TREE_DEPTH];
    logic [rast_pkg::VAL_W-1:0] tree_pend [rast_pkg::TREE_DEPTH];
    logic [rast_pkg::IDX_W-1:0] shadow_last;
    logic [rast_pkg::VAL_W-1:0] sum_queue [$];

    int   errors = 0;
    int   n_words = 0;
    int   n_sums = 0;
    int   n_checked = 0;
    int   cycles = 0;
    bit   idle_en = 1'b0;

    function automatic int wrap_node(int node);
        return (node < rast_pkg::TREE_DEPTH) ? node : 0;
    endfunction

    function automatic void settle_node(int node, int lo, int hi);
        int n;
        int a;
        int b;
        logic [rast_pkg::VAL_W-1:0] p;
        n = wrap_node(node);
        p = tree_pend[n];
        if (p != 0) begin
            tree_sum[n] = tree_sum[n] + rast_pkg::VAL_W'(hi - lo + 1) * p;
            if (lo != hi) begin
                a = wrap_node(2 * node);
                b = wrap_node(2 * node + 1);
                tree_pend[a] = tree_pend[a] + p;
                tree_pend[b] = tree_pend[b] + p;
            end
            tree_pend[n] = '0;
        end
    endfunction

    function automatic void tree_add(int node, int lo, int hi, int ql, int qh,
                                     logic [rast_pkg::VAL_W-1:0] amt);
        int n;
        int a;
        int b;
        int mid;
        n = wrap_node(node);
        settle_node(node, lo, hi);
        if (hi < ql || qh < lo) return;
        a = wrap_node(2 * node);
        b = wrap_node(2 * node + 1);
        if (ql <= lo && hi <= qh) begin
            tree_sum[n] = tree_sum[n] + rast_pkg::VAL_W'(hi - lo + 1) * amt;
            if (lo != hi) begin
                tree_pend[a] = tree_pend[a] + amt;
                tree_pend[b] = tree_pend[b] + amt;
            end
            return;
        end
        mid = (lo + hi) / 2;
        tree_add(2 * node, lo, mid, ql, qh, amt);
        tree_add(2 * node + 1, mid + 1, hi, ql, qh, amt);
        tree_sum[n] = tree_sum[a] + tree_sum[b];
    endfunction

    function automatic logic [rast_pkg::VAL_W-1:0] tree_total(int node, int lo, int hi,
                                                              int ql, int qh);
        int mid;
        settle_node(node, lo, hi);
        if (hi < ql || qh < lo) return '0;
        if (ql <= lo && hi <= qh) return tree_sum[wrap_node(node)];
        mid = (lo + hi) / 2;
        return tree_total(2 * node, lo, mid, ql, qh)
             + tree_total(2 * node + 1, mid + 1, hi, ql, qh);
    endfunction

    function automatic void predict_word(logic op, int ql, int qh,
                                         logic [rast_pkg::VAL_W-1:0] amt);
        logic [rast_pkg::VAL_W-1:0] res;
        res = '0;
        if (ql <= qh) begin
            if (op == rast_pkg::OP_ADD) tree_add(1, 0, int'(shadow_last), ql, qh, amt);
            else res = tree_total(1, 0, int'(shadow_last), ql, qh);
        end
        sum_queue.push_back(res);
    endfunction

    task automatic send_word(logic op, int ql, int qh, logic [rast_pkg::VAL_W-1:0] amt);
        if (idle_en && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_en && $urandom_range(0, 99) < 20) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_range_low <= rast_pkg::IDX_W'(ql);
        s_range_high <= rast_pkg::IDX_W'(qh);
        s_add_value <= amt;
        predict_word(op, ql, qh, amt);
        if (op == rast_pkg::OP_SUM) n_sums++;
        n_words++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_last(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= rast_pkg::IDX_W'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_last = rast_pkg::IDX_W'(v);
        @(posedge aclk);
    endtask

    // check results
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (sum_queue.size() == 0) begin
                    $display("%0t: unexpected word, actual %0d", $time, m_range_sum);
                    errors++;
                end else begin
                    if (m_range_sum !== sum_queue[0]) begin
                        $display("%0t: range_sum expected %0d actual %0d", $time,
                                 $signed(sum_queue[0]), m_range_sum);
                        errors++;
                    end
                    void'(sum_queue.pop_front());
                    n_checked++;
                end
            end
            m_ready <= !(idle_en && $urandom_range(0, 99) < 20);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic test_directed_full();
        send_word(rast_pkg::OP_ADD, 0, 1023, 32'h7fffffff);
        send_word(rast_pkg::OP_ADD, 0, 0, 32'h80000000);
        send_word(rast_pkg::OP_SUM, 0, 1023, 0);
        send_word(rast_pkg::OP_SUM, 0, 0, 0);
        send_word(rast_pkg::OP_ADD, 1023, 1023, 32'hffffffff);
        send_word(rast_pkg::OP_SUM, 1023, 1023, 0);
        send_word(rast_pkg::OP_ADD, 600, 5, 32'h12345678);
        send_word(rast_pkg::OP_SUM, 9, 3, 0);
        send_word(rast_pkg::OP_ADD, 341, 682, 32'h5555aaaa);
        send_word(rast_pkg::OP_SUM, 300, 700, 0);
        send_word(rast_pkg::OP_SUM, 512, 512, 0);
    endtask

    task automatic test_directed_small();
        write_last(1);
        send_word(rast_pkg::OP_ADD, 0, 1023, 32'd7);
        send_word(rast_pkg::OP_SUM, 1, 1023, 0);
        send_word(rast_pkg::OP_SUM, 0, 1, 0);
        write_last(0);
        send_word(rast_pkg::OP_ADD, 0, 0, 32'h80000001);
        send_word(rast_pkg::OP_SUM, 0, 1023, 0);
        send_word(rast_pkg::OP_SUM, 1, 1023, 0);
        write_last(1023);
        send_word(rast_pkg::OP_SUM, 0, 1023, 0);
    endtask

    task automatic random_phase(int count, int size);
        int lo;
        int hi;
        logic op;
        for (int i = 0; i < count; i++) begin
            op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                lo = $urandom_range(0, 1023);
                hi = $urandom_range(0, 1023);
            end else begin
                lo = $urandom_range(0, size);
                hi = $urandom_range(lo, size + 4 > 1023 ? 1023 : size + 4);
            end
            send_word(op, lo, hi, $urandom());
        end
    endtask

    task automatic test_random();
        idle_en = 1'b1;
        write_last(37);
        random_phase(120, 37);
        write_last(1023);
        random_phase(120, 1023);
        write_last(200);
        random_phase(100, 200);
        idle_en = 1'b0;
        random_phase(40, 200);
        idle_en = 1'b1;
        write_last(5);
        random_phase(70, 5);
    endtask

    initial begin
        shadow_last = rast_pkg::LAST_INDEX_RESET;
        for (int i = 0; i < rast_pkg::TREE_DEPTH; i++) begin
            tree_sum[i] = '0;
            tree_pend[i] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        m_ready <= 1'b1;
        test_directed_full();
        test_directed_small();
        test_random();
        drain();
        $display("covered %0d words (%0d sum queries), %0d results checked",
                 n_words, n_sums, n_checked);
        $display("last_index settings 0, 1, 5, 37, 200, 1023 with random stalls");
        if (errors == 0 && sum_queue.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
